@@ rtl/assert_macros.svh @@
// Assertion macros shared by the tracker RTL.
// The macros expect clk in the using module; MFT_ASSERT also needs rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge outside reset.
`define MFT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define MFT_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/mft_pkg.sv @@
// Shared types and constants of the multi-turn tracker.
// No dependencies.
package mft_pkg;

  localparam int REV_COUNTS = 8192;
  localparam int HALF_REV   = 4096;

  typedef struct packed {
    logic [31:0] total;
    logic [15:0] speed;
    logic [15:0] angle;
  } mft_entry_t;

endpackage

@@ rtl/mft_state_mem.sv @@
// Per-slot state memory: one write and one registered read port, per-entry valid bits.
// Forwards the most recent write to the read output. Depends on mft_pkg.
module mft_state_mem
  import mft_pkg::*;
#(
  parameter int DEPTH = 8,
  parameter int AW    = 3
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_idx,
  output mft_entry_t    rd_q,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_idx,
  input  mft_entry_t    wr_data
);

  mft_entry_t           mem [DEPTH];
  logic [DEPTH-1:0]     vld_r;
  mft_entry_t           rd_data_r;
  logic [AW-1:0]        rd_idx_r;
  logic                 fwd_vld_r;
  logic [AW-1:0]        fwd_idx_r;
  mft_entry_t           fwd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_idx] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= vld_r[rd_idx] ? mem[rd_idx] : '0;
      rd_idx_r  <= rd_idx;
    end
    if (wr_en) begin
      fwd_idx_r  <= wr_idx;
      fwd_data_r <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r     <= '0;
      fwd_vld_r <= 1'b0;
    end else if (wr_en) begin
      vld_r[wr_idx] <= 1'b1;
      fwd_vld_r     <= 1'b1;
    end
  end

  // latest write to the entry wins over the array copy
  assign rd_q = (fwd_vld_r && (fwd_idx_r == rd_idx_r)) ? fwd_data_r : rd_data_r;

endmodule

@@ rtl/mft_unwrap.sv @@
// Angle unwrap: new slot state from the stored state and the frame's angle and speed.
// Depends on mft_pkg.
module mft_unwrap
  import mft_pkg::*;
(
  input  mft_entry_t  old_entry,
  input  logic [15:0] angle,
  input  logic [15:0] speed,
  output mft_entry_t  new_entry
);

  localparam logic signed [17:0] REV18 = 18'(REV_COUNTS);

  logic signed [16:0] delta;
  logic signed [17:0] delta18;
  logic signed [17:0] adj;

  always_comb begin
    delta   = $signed({1'b0, angle}) - $signed({1'b0, old_entry.angle});
    delta18 = 18'(delta);
    adj     = '0;
    if (old_entry.speed != 16'd0) begin
      if (delta < -HALF_REV) begin
        adj = delta18 + REV18;
      end else if (delta > HALF_REV) begin
        adj = delta18 - REV18;
      end else if ((delta > -HALF_REV) && (delta < HALF_REV)) begin
        adj = delta18;
      end
    end
    new_entry.total = old_entry.total + 32'(adj);
    new_entry.speed = speed;
    new_entry.angle = angle;
  end

endmodule

@@ rtl/motor_feedback_multiturn_tracker_unit.sv @@
// Motor feedback multi-turn tracker, top level.
// Uses mft_pkg, mft_state_mem, mft_unwrap and assert_macros.svh.
//
// Input channel (in_valid/in_ready): one feedback frame per transfer, a slot
// number and seven payload bytes. Result channel (out_valid/out_ready): one
// result per frame with the decoded angle, speed, current, temperature and
// the slot's accumulated total angle after that frame.
// Path: each frame passes the read stage register, then the output register.
// Throughput: one frame per cycle while results are taken; each slot's
// read-modify-write spans the registered state read and the write-back as
// the frame leaves; the last write is forwarded so frames to one slot see it.
// Slots at or above NUM_MOTORS touch no state and report a total of zero.
// Reset: synchronous, active low; all slots read as zero afterwards through
// per-entry valid bits, no clearing pass.
// Receiver stall: the output register holds its result; one more frame is
// held in the read stage, after which in_ready drops until out_ready returns.
`include "assert_macros.svh"

module motor_feedback_multiturn_tracker_unit
  import mft_pkg::*;
#(
  parameter int NUM_MOTORS = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0]         in_slot,
  input  logic [7:0]         in_angle_hi,
  input  logic [7:0]         in_angle_lo,
  input  logic [7:0]         in_speed_hi,
  input  logic [7:0]         in_speed_lo,
  input  logic [7:0]         in_current_hi,
  input  logic [7:0]         in_current_lo,
  input  logic [7:0]         in_temperature_in,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [2:0]         out_slot_out,
  output logic [15:0]        out_angle,
  output logic signed [15:0] out_speed,
  output logic signed [15:0] out_current,
  output logic [7:0]         out_temperature,
  output logic signed [31:0] out_total_angle_out
);

  localparam int AW = (NUM_MOTORS > 1) ? $clog2(NUM_MOTORS) : 1;

  logic          in_xfer;
  logic          in_range;
  logic          s1_adv;
  logic          s1_valid_r;
  logic [2:0]    s1_slot_r;
  logic [15:0]   s1_ang_r;
  logic [15:0]   s1_spd_r;
  logic [15:0]   s1_cur_r;
  logic [7:0]    s1_temp_r;
  logic          s1_inr_r;
  logic          out_valid_r;
  logic [2:0]    out_slot_r;
  logic [15:0]   out_ang_r;
  logic [15:0]   out_spd_r;
  logic [15:0]   out_cur_r;
  logic [7:0]    out_temp_r;
  logic [31:0]   out_tot_r;
  logic          wr_en;
  mft_entry_t    old_entry;
  mft_entry_t    new_entry;

  assign in_range = (32'(in_slot) < NUM_MOTORS);
  assign s1_adv   = !out_valid_r || out_ready;
  assign in_ready = !s1_valid_r || s1_adv;
  assign in_xfer  = in_valid && in_ready;
  assign wr_en    = s1_valid_r && s1_adv && s1_inr_r;

  mft_state_mem #(
    .DEPTH (NUM_MOTORS),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (in_xfer && in_range),
    .rd_idx  (AW'(in_slot)),
    .rd_q    (old_entry),
    .wr_en   (wr_en),
    .wr_idx  (AW'(s1_slot_r)),
    .wr_data (new_entry)
  );

  mft_unwrap u_unwrap (
    .old_entry (old_entry),
    .angle     (s1_ang_r),
    .speed     (s1_spd_r),
    .new_entry (new_entry)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_ready) begin
        s1_valid_r <= in_valid;
      end
      if (s1_adv) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_slot_r <= in_slot;
      s1_ang_r  <= {in_angle_hi, in_angle_lo};
      s1_spd_r  <= {in_speed_hi, in_speed_lo};
      s1_cur_r  <= {in_current_hi, in_current_lo};
      s1_temp_r <= in_temperature_in;
      s1_inr_r  <= in_range;
    end
    if (s1_adv && s1_valid_r) begin
      out_slot_r <= s1_slot_r;
      out_ang_r  <= s1_ang_r;
      out_spd_r  <= s1_spd_r;
      out_cur_r  <= s1_cur_r;
      out_temp_r <= s1_temp_r;
      out_tot_r  <= s1_inr_r ? new_entry.total : 32'd0;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_slot_out        = out_slot_r;
  assign out_angle           = out_ang_r;
  assign out_speed           = $signed(out_spd_r);
  assign out_current         = $signed(out_cur_r);
  assign out_temperature     = out_temp_r;
  assign out_total_angle_out = $signed(out_tot_r);

  `MFT_ASSERT(a_oor_total_zero, (out_valid_r && (32'(out_slot_r) >= NUM_MOTORS)) |-> (out_tot_r == 32'd0), "out-of-range slot reported a nonzero total")
  `MFT_ASSERT(a_ready_only_full, !in_ready |-> (s1_valid_r && out_valid_r && !out_ready), "input stalled while the pipeline had room")
  `MFT_ASSERT(a_s1_to_out, (s1_valid_r && s1_adv) |=> out_valid_r, "frame in read stage was lost on its way to the output")
  `MFT_ASSERT_ALWAYS(a_wr_needs_frame, wr_en |-> s1_valid_r, "state write without a frame in the read stage")

endmodule
